// ----- src/mb48_pkg.sv -----
// Shared types and constants for the mapper 48 bank and IRQ controller.
// Used by the front classifier, the command queue, the back end and the top level.
`default_nettype none

package mb48_pkg;

    // Request types on the input side.
    localparam logic [1:0] REQ_CPU_WRITE = 2'd0;
    localparam logic [1:0] REQ_TICK      = 2'd1;
    localparam logic [1:0] REQ_PRG       = 2'd2;
    localparam logic [1:0] REQ_CHR       = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_PRG_MASK = 1'b0;
    localparam logic CFG_CHR_MASK = 1'b1;

    localparam logic [7:0] PRG_MASK_RESET = 8'hFF;
    localparam logic [8:0] CHR_MASK_RESET = 9'h1FF;

    // Register groups selected by CPU address bits 15:13.
    localparam logic [2:0] GRP_8000 = 3'b100;
    localparam logic [2:0] GRP_A000 = 3'b101;
    localparam logic [2:0] GRP_C000 = 3'b110;
    localparam logic [2:0] GRP_E000 = 3'b111;

    // Register selects within the 0xC000 group (address bits 1:0).
    localparam logic [1:0] SUB_LATCH   = 2'd0;
    localparam logic [1:0] SUB_RELOAD  = 2'd1;
    localparam logic [1:0] SUB_ENABLE  = 2'd2;
    localparam logic [1:0] SUB_DISABLE = 2'd3;

    // First of the four 1KB CHR bank registers.
    localparam logic [2:0] CHR_1K_BASE = 3'd2;

    // Upper seven bits of the fixed PRG bank number for the last 16KB.
    localparam logic [6:0] PRG_FIXED_HI = 7'h7F;

    // Counter value that raises the IRQ.
    localparam logic [8:0] IRQ_FIRE = 9'h100;

    localparam int CMD_FIFO_DEPTH = 4;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_PRG_BANK,
        CMD_CHR_BANK,
        CMD_IRQ_LATCH,
        CMD_IRQ_RELOAD,
        CMD_IRQ_ENABLE,
        CMD_IRQ_DISABLE,
        CMD_MIRROR,
        CMD_TICK,
        CMD_PRG_SW,
        CMD_PRG_FIX,
        CMD_CHR_2K,
        CMD_CHR_1K
    } mb48_kind_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        mb48_kind_t  kind;
        logic [2:0]  sel;     // bank register or slot index
        logic        low;     // low bank bit for 2KB CHR windows
        logic [12:0] offset;  // byte offset within the window
        logic [7:0]  data;    // CPU write data
    } mb48_cmd_t;

    typedef struct packed {
        logic [20:0] rom_addr;
        logic        addr_hit;
        logic        mirror_vertical;
        logic        irq_line;
    } mb48_result_t;

endpackage

`default_nettype wire

// ----- src/nes_mapper48_bank_irq.sv -----
// Mapper 48 bank switching and scanline IRQ controller, top level.
// A pushed word is written into the command queue, then into the result register.
// Throughput: one word per cycle in and out while full is low and results are popped;
// the command queue and the result register let push and pop stall independently.
// Reset (rst_n, asynchronous, active low): banks, mirroring and IRQ state clear to
// zero, both bank masks to all ones, queue and result register empty.
`default_nettype none

module nes_mapper48_bank_irq
    import mb48_pkg::*;
#(
    parameter int FIFO_DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port: index 0 is the PRG mask, index 1 the CHR mask.
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    // Request side.
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  data,
    // Result side.
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      rom_addr,
    output logic             addr_hit,
    output logic             mirror_vertical,
    output logic             irq_line
);

    // The front decodes each request word into a command: register writes are
    // split by address bits 15:13 and 1:0, and translate requests are checked
    // against their window and reduced to a bank slot plus an offset.
    mb48_cmd_t    front_cmd;
    mb48_cmd_t    queue_cmd;
    logic         queue_valid;
    logic         queue_take;
    logic         res_valid;
    mb48_result_t res;

    mb48_front u_front
    (
        .req_type (req_type),
        .addr     (addr),
        .data     (data),
        .cmd      (front_cmd)
    );

    // A word is accepted whenever the queue has room; the queue decouples the
    // front from the back so a stalled result side does not block the input
    // until the queue fills.
    mb48_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push && !full),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (queue_take),
        .rd_cmd (queue_cmd),
        .valid  (queue_valid)
    );

    // The back takes the oldest command whenever its result register is free
    // or is being emptied in the same cycle, so commands leave in order and
    // each state update is seen by the result of its own word.
    mb48_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_take  (queue_take),
        .res_take  (pop && !empty),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty           = !res_valid;
    assign rom_addr        = res.rom_addr;
    assign addr_hit        = res.addr_hit;
    assign mirror_vertical = res.mirror_vertical;
    assign irq_line        = res.irq_line;

endmodule

`default_nettype wire

// ----- src/mb48_front.sv -----
// Front classifier: turns one request word into a decoded command.
// Depends on mb48_pkg for the command type and decode constants.
`default_nettype none

module mb48_front
    import mb48_pkg::*;
(
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  data,
    output mb48_cmd_t        cmd
);

    always_comb
    begin
        cmd.kind   = CMD_NOP;
        cmd.sel    = 3'd0;
        cmd.low    = 1'b0;
        cmd.offset = addr[12:0];
        cmd.data   = data;
        case (req_type)
            REQ_CPU_WRITE:
            begin
                case (addr[15:13])
                    GRP_8000:
                    begin
                        cmd.kind = addr[1] ? CMD_CHR_BANK : CMD_PRG_BANK;
                        cmd.sel  = {2'b00, addr[0]};
                    end
                    GRP_A000:
                    begin
                        cmd.kind = CMD_CHR_BANK;
                        cmd.sel  = CHR_1K_BASE + {1'b0, addr[1:0]};
                    end
                    GRP_C000:
                    begin
                        case (addr[1:0])
                            SUB_LATCH:   cmd.kind = CMD_IRQ_LATCH;
                            SUB_RELOAD:  cmd.kind = CMD_IRQ_RELOAD;
                            SUB_ENABLE:  cmd.kind = CMD_IRQ_ENABLE;
                            SUB_DISABLE: cmd.kind = CMD_IRQ_DISABLE;
                            default:     cmd.kind = CMD_NOP;
                        endcase
                    end
                    GRP_E000:
                    begin
                        if (addr[1:0] == 2'b00)
                        begin
                            cmd.kind = CMD_MIRROR;
                        end
                    end
                    default:
                    begin
                        cmd.kind = CMD_NOP;
                    end
                endcase
            end
            REQ_TICK:
            begin
                cmd.kind = CMD_TICK;
            end
            REQ_PRG:
            begin
                if (addr[15])
                begin
                    cmd.kind = addr[14] ? CMD_PRG_FIX : CMD_PRG_SW;
                    cmd.sel  = {2'b00, addr[13]};
                end
            end
            REQ_CHR:
            begin
                if (addr[15:13] == 3'b000)
                begin
                    if (addr[12])
                    begin
                        cmd.kind = CMD_CHR_1K;
                        cmd.sel  = CHR_1K_BASE + {1'b0, addr[11:10]};
                    end
                    else
                    begin
                        cmd.kind = CMD_CHR_2K;
                        cmd.sel  = {2'b00, addr[11]};
                        cmd.low  = addr[10];
                    end
                end
            end
            default:
            begin
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/mb48_cmd_fifo.sv -----
// Short command queue between the front classifier and the back end.
// Depends on mb48_pkg for the command type and the default depth.
`default_nettype none

module mb48_cmd_fifo
    import mb48_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire mb48_cmd_t wr_cmd,
    output logic           full,
    input  wire logic      rd_en,
    output mb48_cmd_t      rd_cmd,
    output logic           valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mb48_cmd_t         mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign rd_cmd = mem_reg[rd_ptr_reg];
    assign full   = (count_reg == CW'(DEPTH));
    assign valid  = (count_reg != '0);

endmodule

`default_nettype wire

// ----- src/mb48_back.sv -----
// Back end: holds the bank, mirroring and IRQ state, executes commands and
// registers one result word. Depends on mb48_pkg for command and result types.
`default_nettype none

module mb48_back
    import mb48_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [8:0] cfg_data,
    input  wire logic       cmd_valid,
    input  wire mb48_cmd_t  cmd,
    output logic            cmd_take,
    input  wire logic       res_take,
    output logic            res_valid,
    output mb48_result_t    res
);

    logic [7:0]   prg_mask_reg;
    logic [8:0]   chr_mask_reg;
    logic [7:0]   prg_banks_reg [2];
    logic [7:0]   chr_banks_reg [6];
    logic         mirror_reg, mirror_next;
    logic [7:0]   irq_latch_reg, irq_latch_next;
    logic [8:0]   irq_counter_reg, irq_counter_next;
    logic         irq_enabled_reg, irq_enabled_next;
    logic         irq_pending_reg, irq_pending_next;
    logic         res_valid_reg, res_valid_next;
    mb48_result_t res_reg, res_next;

    logic [8:0]   cnt_inc;
    logic [7:0]   prg_bank;
    logic [8:0]   chr_bank;

    assign cmd_take = cmd_valid && (!res_valid_reg || res_take);
    assign cnt_inc  = irq_counter_reg + 9'd1;

    always_comb
    begin
        mirror_next      = mirror_reg;
        irq_latch_next   = irq_latch_reg;
        irq_counter_next = irq_counter_reg;
        irq_enabled_next = irq_enabled_reg;
        irq_pending_next = irq_pending_reg;
        case (cmd.kind)
            CMD_IRQ_LATCH:   irq_latch_next   = cmd.data;
            CMD_IRQ_RELOAD:  irq_counter_next = {1'b0, irq_latch_reg};
            CMD_IRQ_ENABLE:  irq_enabled_next = 1'b1;
            CMD_IRQ_DISABLE:
            begin
                irq_enabled_next = 1'b0;
                irq_pending_next = 1'b0;
            end
            CMD_MIRROR:      mirror_next      = cmd.data[6];
            CMD_TICK:
            begin
                if (irq_enabled_reg)
                begin
                    irq_counter_next = cnt_inc;
                    if (cnt_inc == IRQ_FIRE)
                    begin
                        irq_pending_next = 1'b1;
                        irq_enabled_next = 1'b0;
                    end
                end
            end
            default:
            begin
                mirror_next = mirror_reg;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.kind == CMD_PRG_SW)
        begin
            prg_bank = prg_banks_reg[cmd.sel[0]] & prg_mask_reg;
        end
        else
        begin
            prg_bank = {PRG_FIXED_HI, cmd.sel[0]} & prg_mask_reg;
        end
        if (cmd.kind == CMD_CHR_2K)
        begin
            chr_bank = {chr_banks_reg[cmd.sel], cmd.low} & chr_mask_reg;
        end
        else
        begin
            chr_bank = {1'b0, chr_banks_reg[cmd.sel]} & chr_mask_reg;
        end

        res_next.rom_addr        = '0;
        res_next.addr_hit        = 1'b0;
        res_next.mirror_vertical = !mirror_next;
        res_next.irq_line        = irq_pending_next;
        case (cmd.kind)
            CMD_PRG_SW, CMD_PRG_FIX:
            begin
                res_next.rom_addr = {prg_bank, cmd.offset};
                res_next.addr_hit = 1'b1;
            end
            CMD_CHR_2K, CMD_CHR_1K:
            begin
                res_next.rom_addr = {2'b00, chr_bank, cmd.offset[9:0]};
                res_next.addr_hit = 1'b1;
            end
            default:
            begin
                res_next.addr_hit = 1'b0;
            end
        endcase

        if (cmd_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_take)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg     <= PRG_MASK_RESET;
            chr_mask_reg     <= CHR_MASK_RESET;
            prg_banks_reg[0] <= '0;
            prg_banks_reg[1] <= '0;
            for (int i = 0; i < 6; i++)
            begin
                chr_banks_reg[i] <= '0;
            end
            mirror_reg       <= 1'b0;
            irq_latch_reg    <= '0;
            irq_counter_reg  <= '0;
            irq_enabled_reg  <= 1'b0;
            irq_pending_reg  <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PRG_MASK)
                begin
                    prg_mask_reg <= cfg_data[7:0];
                end
                else
                begin
                    chr_mask_reg <= cfg_data;
                end
            end
            res_valid_reg <= res_valid_next;
            if (cmd_take)
            begin
                if (cmd.kind == CMD_PRG_BANK)
                begin
                    prg_banks_reg[cmd.sel[0]] <= cmd.data;
                end
                if (cmd.kind == CMD_CHR_BANK)
                begin
                    chr_banks_reg[cmd.sel] <= cmd.data;
                end
                mirror_reg      <= mirror_next;
                irq_latch_reg   <= irq_latch_next;
                irq_counter_reg <= irq_counter_next;
                irq_enabled_reg <= irq_enabled_next;
                irq_pending_reg <= irq_pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- src/mb48_checker.sv -----
// Port-level checker for the mapper 48 controller, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module mb48_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [20:0] rom_addr,
    input wire logic        addr_hit,
    input wire logic        mirror_vertical,
    input wire logic        irq_line
);

    // A waiting result word holds until it is popped.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(rom_addr) && $stable(addr_hit)
            && $stable(mirror_vertical) && $stable(irq_line))
        else $error("result word changed while stalled");

    // A word outside any translation window carries a zero ROM address.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !addr_hit |-> rom_addr == 21'd0)
        else $error("missed translation with nonzero ROM address");

    // With the result register free the back drains the queue, so the input
    // side cannot stay full when nothing new arrives.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !push |=> !full)
        else $error("queue stayed full while the back end was free");

endmodule

bind nes_mapper48_bank_irq mb48_checker u_mb48_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .rom_addr        (rom_addr),
    .addr_hit        (addr_hit),
    .mirror_vertical (mirror_vertical),
    .irq_line        (irq_line)
);

`default_nettype wire

// ----- bench/nes_mapper48_bank_irq_tb.sv -----
// Self-checking testbench for the mapper 48 bank switching and scanline IRQ controller.
// Depends on mb48_pkg for request codes, register selects and the result layout,
// and on the nes_mapper48_bank_irq top level as the device under test.
`timescale 1ns / 1ps

module nes_mapper48_bank_irq_tb
    import mb48_pkg::*;
();

    // Each phase of random traffic stops once this many words that change or
    // observe the mapper have been queued.
    localparam int PHASE_WORDS  = 210;
    localparam int RANDOM_PHASES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;

    // One request word as the sender sees it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } bus_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_PRG_MASK;
    logic [8:0]  cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = REQ_CPU_WRITE;
    logic [15:0] addr = '0;
    logic [7:0]  data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [20:0] rom_addr;
    logic        addr_hit;
    logic        mirror_vertical;
    logic        irq_line;

    nes_mapper48_bank_irq dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .addr            (addr),
        .data            (data),
        .empty           (empty),
        .pop             (pop),
        .rom_addr        (rom_addr),
        .addr_hit        (addr_hit),
        .mirror_vertical (mirror_vertical),
        .irq_line        (irq_line)
    );

    always #5 clk = ~clk;

    // Shadow copy of the mapper. It starts in the reset state and is only
    // advanced when a request word is actually accepted by the block.
    logic [7:0] prg_mask_q = PRG_MASK_RESET;
    logic [8:0] chr_mask_q = CHR_MASK_RESET;
    logic [7:0] prg_bank_q [0:1] = '{default: 8'h00};
    logic [7:0] chr_bank_q [0:5] = '{default: 8'h00};
    logic       mirror_q = 1'b0;
    logic [7:0] irq_latch_q = 8'h00;
    logic [8:0] irq_count_q = 9'h000;
    logic       irq_armed_q = 1'b0;
    logic       irq_flag_q = 1'b0;

    bus_req_t     pending_reqs [$];
    mb48_result_t due_results [$];
    bus_req_t     next_req;
    mb48_result_t want, got;

    int words_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int phase_words = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 58;
    int rx_hold = 0;
    int cycle_count = 0;

    // Applies one request word to the shadow state and returns the result word
    // the block must produce for it. Mirroring and IRQ reflect the state after
    // the request has taken effect.
    function automatic mb48_result_t map_request(input logic [1:0] kind,
                                                 input logic [15:0] a,
                                                 input logic [7:0] d);
        mb48_result_t res;
        logic [7:0]   pbank;
        logic [8:0]   cbank;
        res = '0;
        case (kind)
            REQ_CPU_WRITE: begin
                // Only address bits 15:13 and 1:0 take part in the decode.
                case (a[15:13])
                    GRP_8000: begin
                        if (!a[1])
                            prg_bank_q[a[0]] = d;
                        else
                            chr_bank_q[a[0]] = d;
                    end
                    GRP_A000: chr_bank_q[CHR_1K_BASE + a[1:0]] = d;
                    GRP_C000: begin
                        case (a[1:0])
                            SUB_LATCH:  irq_latch_q = d;
                            SUB_RELOAD: irq_count_q = {1'b0, irq_latch_q};
                            SUB_ENABLE: irq_armed_q = 1'b1;
                            SUB_DISABLE: begin
                                irq_armed_q = 1'b0;
                                irq_flag_q  = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    GRP_E000: begin
                        if (a[1:0] == 2'b00)
                            mirror_q = d[6];
                    end
                    default: ;
                endcase
            end
            REQ_TICK: begin
                // The counter is nine bits wide and wraps, so a re-enable
                // without reload fires again only after a full lap.
                if (irq_armed_q) begin
                    irq_count_q = irq_count_q + 9'd1;
                    if (irq_count_q == IRQ_FIRE) begin
                        irq_flag_q  = 1'b1;
                        irq_armed_q = 1'b0;
                    end
                end
            end
            REQ_PRG: begin
                if (a[15]) begin
                    // The upper two 8KB slots show the last two banks of the ROM.
                    pbank = a[14] ? {PRG_FIXED_HI, a[13]} : prg_bank_q[a[13]];
                    pbank = pbank & prg_mask_q;
                    res.rom_addr = {pbank, a[12:0]};
                    res.addr_hit = 1'b1;
                end
            end
            REQ_CHR: begin
                if (a[15:13] == 3'b000) begin
                    if (!a[12])
                        cbank = {chr_bank_q[a[11]], a[10]};
                    else
                        cbank = {1'b0, chr_bank_q[CHR_1K_BASE + a[11:10]]};
                    cbank = cbank & chr_mask_q;
                    res.rom_addr = {2'b00, cbank, a[9:0]};
                    res.addr_hit = 1'b1;
                end
            end
            default: ;
        endcase
        res.mirror_vertical = ~mirror_q;
        res.irq_line        = irq_flag_q;
        return res;
    endfunction

    // Queues one request word. Writes that no register decodes are noise and
    // do not count toward the size of a phase.
    task automatic add_req(input logic [1:0] kind, input logic [15:0] a, input logic [7:0] d);
        pending_reqs.push_back('{kind, a, d});
        if (kind != REQ_CPU_WRITE || (a[15] && !(a[15:13] == GRP_E000 && a[1:0] != 2'b00)))
            phase_words++;
    endtask

    // Register address with random don't-care bits between the decoded ones.
    function automatic logic [15:0] reg_addr(input logic [2:0] grp, input logic [1:0] sub);
        return {grp, 11'($urandom), sub};
    endfunction

    // Mostly addresses inside the PRG window, now and then anywhere.
    function automatic logic [15:0] prg_addr();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : {1'b1, 15'($urandom)};
    endfunction

    function automatic logic [15:0] chr_addr();
        return ($urandom_range(0, 6) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)};
    endfunction

    // Mask registers are written only while nothing is in flight, so the
    // shadow copy can be updated at once.
    task automatic write_mask(input logic idx, input logic [8:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PRG_MASK)
            prg_mask_q = value[7:0];
        else
            chr_mask_q = value;
    endtask

    // Waits until every queued word has been sent and every result has come
    // back. The state is sampled on the falling edge, away from the updates.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || push || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Sender. A word is accepted at an edge where push is high and full is
    // low; the shadow model sees it at that same edge. The offered word is
    // held steady while the block reports full.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                due_results.push_back(map_request(req_type, addr, data));
                words_accepted <= words_accepted + 1;
            end
            if (!push || !full) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    push     <= 1'b1;
                    req_type <= next_req.kind;
                    addr     <= next_req.addr;
                    data     <= next_req.data;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker. The result ports are sampled at the edge where the
    // word is taken. words_accepted is updated by nonblocking assignment, so
    // its value here counts only words accepted at earlier edges.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = '{rom_addr, addr_hit, mirror_vertical, irq_line};
                if (results_seen >= words_accepted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing outstanding: rom_addr=%h hit=%b",
                                 $realtime, got.rom_addr, got.addr_hit);
                end else begin
                    want = due_results.pop_front();
                    if (got.rom_addr !== want.rom_addr || got.addr_hit !== want.addr_hit ||
                        got.mirror_vertical !== want.mirror_vertical ||
                        got.irq_line !== want.irq_line) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: word %0d expected rom_addr=%h hit=%b mv=%b irq=%b,",
                                     $realtime, results_seen, want.rom_addr, want.addr_hit,
                                     want.mirror_vertical, want.irq_line,
                                     " got rom_addr=%h hit=%b mv=%b irq=%b",
                                     got.rom_addr, got.addr_hit, got.mirror_vertical,
                                     got.irq_line);
                    end
                end
                results_seen++;
                // Twice in the run the receiver stops taking words for a long
                // stretch while the sender keeps offering, so the command queue
                // fills and full has to hold the sender off.
                if (results_seen == 200 || results_seen == 1000)
                    rx_hold = LONG_HOLD;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int          phase;
        int          pick;
        int          sel;
        int          n;
        logic [8:0]  prg_cfg;
        logic [8:0]  chr_cfg;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with the masks at their reset values. Banks start at
        // zero, so the first translations land at the bottom of each ROM.
        add_req(REQ_PRG, 16'h8000, 8'h00);
        add_req(REQ_PRG, 16'h7FFF, 8'hFF);         // below the PRG window
        add_req(REQ_CHR, 16'h1FFF, 8'h00);
        add_req(REQ_CHR, 16'h2000, 8'h00);         // past the CHR window
        add_req(REQ_CPU_WRITE, 16'h8000, 8'hFF);   // PRG bank 0
        add_req(REQ_CPU_WRITE, 16'h9FFD, 8'h55);   // PRG bank 1, middle bits set
        add_req(REQ_CPU_WRITE, 16'h8002, 8'hFF);   // first 2KB CHR bank
        add_req(REQ_CPU_WRITE, 16'hBFFF, 8'h80);   // last 1KB CHR bank
        add_req(REQ_CPU_WRITE, 16'h7FFF, 8'hFF);   // below any register
        add_req(REQ_CPU_WRITE, 16'hFFFF, 8'hFF);   // undecoded in the top group
        add_req(REQ_CPU_WRITE, 16'hE000, 8'h40);   // horizontal mirroring
        add_req(REQ_PRG, 16'h9FFF, 8'h00);
        add_req(REQ_PRG, 16'hC000, 8'h00);         // fixed second-to-last bank
        add_req(REQ_PRG, 16'hFFFF, 8'h00);         // fixed last bank
        add_req(REQ_CHR, 16'h0400, 8'h00);         // upper half of a 2KB bank
        add_req(REQ_CHR, 16'h1C00, 8'h00);
        add_req(REQ_CPU_WRITE, 16'hC000, 8'hFE);   // latch two ticks short
        add_req(REQ_CPU_WRITE, 16'hC001, 8'h00);   // reload the counter
        add_req(REQ_TICK, 16'h0000, 8'h00);        // disabled, no effect
        add_req(REQ_CPU_WRITE, 16'hC002, 8'h00);
        add_req(REQ_TICK, 16'hFFFF, 8'hFF);
        add_req(REQ_TICK, 16'h0000, 8'h00);        // reaches 256, IRQ fires
        add_req(REQ_CPU_WRITE, 16'hC002, 8'h00);   // re-enable without reload
        add_req(REQ_TICK, 16'h0000, 8'h00);        // counter runs on past 256
        add_req(REQ_CPU_WRITE, 16'hC003, 8'h00);   // acknowledge and disable
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // Each phase runs under its own pair of ROM size masks, the
            // extremes among them. The PRG mask ignores the ninth data bit.
            case (phase)
                0: begin
                    prg_cfg = 9'h000;
                    chr_cfg = 9'h000;
                end
                1: begin
                    prg_cfg = 9'h00F;
                    chr_cfg = 9'h03F;
                end
                2: begin
                    prg_cfg = 9'h1FF;
                    chr_cfg = 9'h1FF;
                end
                4: begin
                    prg_cfg = 9'((1 << $urandom_range(0, 8)) - 1);
                    chr_cfg = 9'((1 << $urandom_range(0, 9)) - 1);
                end
                default: begin
                    prg_cfg = 9'($urandom);
                    chr_cfg = 9'($urandom);
                end
            endcase
            write_mask(CFG_PRG_MASK, prg_cfg);
            write_mask(CFG_CHR_MASK, chr_cfg);

            // Both sides idle unevenly in the first two thirds, swapped after
            // the first third, and run flat out in the last.
            if (phase < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 58;
            end else if (phase < 4) begin
                send_idle_pct = 58;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    // IRQ set-up: latch, usually a reload, enable, then a run of ticks with
                    // the odd PRG translation, mostly closed by a disable. Latches lean high so
                    // the counter actually reaches 256; an occasional long run covers the wrap.
                    add_req(REQ_CPU_WRITE, reg_addr(GRP_C000, SUB_LATCH),
                            ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(200, 255)));
                    if ($urandom_range(0, 4) != 0)
                        add_req(REQ_CPU_WRITE, reg_addr(GRP_C000, SUB_RELOAD), 8'($urandom));
                    add_req(REQ_CPU_WRITE, reg_addr(GRP_C000, SUB_ENABLE), 8'($urandom));
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300)
                                                    : $urandom_range(1, 60);
                    repeat (n) begin
                        add_req(REQ_TICK, 16'($urandom), 8'($urandom));
                        if ($urandom_range(0, 5) == 0)
                            add_req(REQ_PRG, prg_addr(), 8'($urandom));
                    end
                    if ($urandom_range(0, 9) < 6)
                        add_req(REQ_CPU_WRITE, reg_addr(GRP_C000, SUB_DISABLE), 8'($urandom));
                end else if (pick < 80) begin
                    // Bank or mirroring write followed by translations that
                    // are likely to go through the register just written.
                    sel = $urandom_range(0, 8);
                    if (sel < 4)
                        add_req(REQ_CPU_WRITE, reg_addr(GRP_8000, 2'(sel)), 8'($urandom));
                    else if (sel < 8)
                        add_req(REQ_CPU_WRITE, reg_addr(GRP_A000, 2'(sel)), 8'($urandom));
                    else
                        add_req(REQ_CPU_WRITE, reg_addr(GRP_E000, 2'b00), 8'($urandom));
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1) == 0)
                            add_req(REQ_PRG, prg_addr(), 8'($urandom));
                        else
                            add_req(REQ_CHR, chr_addr(), 8'($urandom));
                    end
                end else begin
                    // Noise: any type, any address, any data.
                    add_req(2'($urandom), 16'($urandom), 8'($urandom));
                end
            end
            // The sender stops here until every result of the phase is back.
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mb48_pkg.sv
src/mb48_front.sv
src/mb48_cmd_fifo.sv
src/mb48_back.sv
src/nes_mapper48_bank_irq.sv
src/mb48_checker.sv
bench/nes_mapper48_bank_irq_tb.sv
